[rtl/jnl_pkg.sv]
// ----------------------------------------------------------------------------
// JSON number lexer package
// Shared constants, phase and status codes, and the state and result records
// used by the lexer step logic and the top level.
// ----------------------------------------------------------------------------
package jnl_pkg;

   localparam int unsigned CHAR_W      = 8;
   localparam int unsigned VALUE_W     = 64;
   localparam int unsigned DIGIT_W     = 5;
   localparam int unsigned LEN_W       = 10;
   localparam int unsigned STATUS_W    = 3;
   localparam int unsigned RSP_TDATA_W = 80;

   localparam int unsigned MAX_TOKEN_LENGTH = 1023;
   localparam logic [LEN_W-1:0] LEN_CAP =
      LEN_W'((MAX_TOKEN_LENGTH < 1023) ? MAX_TOKEN_LENGTH : 1023);

   localparam logic [DIGIT_W-1:0] DIGIT_CAP      = 5'd31;
   localparam logic [DIGIT_W-1:0] INT_DIGITS_MAX = 5'd19;

   localparam logic [VALUE_W-1:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

   localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_E_UPPER = 8'h45;
   localparam logic [CHAR_W-1:0] CH_E_LOWER = 8'h65;

   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_SIGN  = 4'd1,
      PH_INT   = 4'd2,
      PH_FRAC0 = 4'd3,
      PH_FRAC  = 4'd4,
      PH_EXP0  = 4'd5,
      PH_EXPS  = 4'd6,
      PH_EXP   = 4'd7,
      PH_START = 4'd8
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INT_OK        = 3'd0,
      ST_NEEDS_DOUBLE  = 3'd1,
      ST_NO_INT_DIGITS = 3'd2,
      ST_LEADING_ZERO  = 3'd3,
      ST_NO_FRAC_DIGITS = 3'd4,
      ST_NO_EXP_DIGITS = 3'd5
   } status_type;

   typedef struct packed {
      phase_type            phase;
      logic                 negative;
      logic [VALUE_W-1:0]   magnitude;
      logic [DIGIT_W-1:0]   digit_count;
      logic                 first_zero;
      logic                 float_seen;
      logic [LEN_W-1:0]     length;
   } state_type;

   typedef struct packed {
      status_type           status;
      logic [VALUE_W-1:0]   value;
      logic [DIGIT_W-1:0]   digit_count;
      logic [LEN_W-1:0]     length;
   } result_type;

endpackage

[rtl/jnl_step.sv]
// ----------------------------------------------------------------------------
// JSON number lexer step
// Next-state and result logic for one byte: grammar phase, sign, decimal
// accumulator, digit and length counts, and the end-of-token result.
// ----------------------------------------------------------------------------
module jnl_step (
   input  jnl_pkg::state_type            state_ff,
   input  logic [jnl_pkg::CHAR_W-1:0]    char_byte,
   input  logic                          token_start,
   output jnl_pkg::state_type            state_in,
   output logic                          emit,
   output jnl_pkg::result_type           result
);

   jnl_pkg::state_type              cur;
   jnl_pkg::state_type              digit_state;
   logic                            is_digit;
   logic                            is_exp;
   logic                            is_sign;
   logic [3:0]                      digit;
   logic [jnl_pkg::LEN_W-1:0]       length_inc;
   logic [jnl_pkg::VALUE_W-1:0]     mag_next;
   logic [jnl_pkg::VALUE_W-1:0]     limit;
   logic                            too_big;
   jnl_pkg::status_type             finish_status;
   logic [jnl_pkg::VALUE_W-1:0]     finish_value;

   always_comb begin
      cur = state_ff;
      if (token_start) begin
         cur = '0;
         cur.phase = jnl_pkg::PH_START;
      end
   end

   assign is_digit = (char_byte >= jnl_pkg::CH_ZERO) && (char_byte <= jnl_pkg::CH_NINE);
   assign is_exp   = (char_byte == jnl_pkg::CH_E_LOWER) || (char_byte == jnl_pkg::CH_E_UPPER);
   assign is_sign  = (char_byte == jnl_pkg::CH_PLUS) || (char_byte == jnl_pkg::CH_MINUS);
   assign digit    = 4'(char_byte - jnl_pkg::CH_ZERO);

   assign length_inc = (cur.length < jnl_pkg::LEN_CAP) ?
                       cur.length + 1'b1 : cur.length;
   assign mag_next   = (cur.magnitude << 3) + (cur.magnitude << 1) +
                       {{(jnl_pkg::VALUE_W-4){1'b0}}, digit};

   always_comb begin
      digit_state = cur;
      if (cur.digit_count == '0) begin
         digit_state.first_zero = (digit == 4'd0);
      end
      if (cur.digit_count < jnl_pkg::INT_DIGITS_MAX) begin
         digit_state.magnitude = mag_next;
      end
      if (cur.digit_count < jnl_pkg::DIGIT_CAP) begin
         digit_state.digit_count = cur.digit_count + 1'b1;
      end
      digit_state.length = length_inc;
      digit_state.phase  = jnl_pkg::PH_INT;
   end

   assign limit   = cur.negative ? jnl_pkg::NEG_LIMIT : jnl_pkg::POS_LIMIT;
   assign too_big = cur.float_seen || (cur.digit_count > jnl_pkg::INT_DIGITS_MAX) ||
                    ((cur.digit_count == jnl_pkg::INT_DIGITS_MAX) &&
                     (cur.magnitude > limit));
   assign finish_status = too_big ? jnl_pkg::ST_NEEDS_DOUBLE : jnl_pkg::ST_INT_OK;
   assign finish_value  = too_big ? '0 :
                          (cur.negative ? (~cur.magnitude + 1'b1) : cur.magnitude);

   always_comb begin
      state_in           = cur;
      emit               = 1'b0;
      result.status      = jnl_pkg::ST_INT_OK;
      result.value       = '0;
      result.digit_count = cur.digit_count;
      result.length      = cur.length;
      unique case (cur.phase)
         jnl_pkg::PH_START: begin
            if (char_byte == jnl_pkg::CH_MINUS) begin
               state_in.negative = 1'b1;
               state_in.length   = length_inc;
               state_in.phase    = jnl_pkg::PH_SIGN;
            end else if (is_digit) begin
               state_in = digit_state;
            end else begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_NO_INT_DIGITS;
            end
         end
         jnl_pkg::PH_SIGN: begin
            if (is_digit) begin
               state_in = digit_state;
            end else begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_NO_INT_DIGITS;
            end
         end
         jnl_pkg::PH_INT: begin
            if (is_digit) begin
               state_in = digit_state;
            end else if (cur.first_zero && (cur.digit_count > 5'd1)) begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_LEADING_ZERO;
            end else if (char_byte == jnl_pkg::CH_DOT) begin
               state_in.float_seen = 1'b1;
               state_in.length     = length_inc;
               state_in.phase      = jnl_pkg::PH_FRAC0;
            end else if (is_exp) begin
               state_in.float_seen = 1'b1;
               state_in.length     = length_inc;
               state_in.phase      = jnl_pkg::PH_EXP0;
            end else begin
               emit          = 1'b1;
               result.status = finish_status;
               result.value  = finish_value;
            end
         end
         jnl_pkg::PH_FRAC0: begin
            if (is_digit) begin
               state_in.length = length_inc;
               state_in.phase  = jnl_pkg::PH_FRAC;
            end else begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_NO_FRAC_DIGITS;
            end
         end
         jnl_pkg::PH_FRAC: begin
            if (is_digit) begin
               state_in.length = length_inc;
            end else if (is_exp) begin
               state_in.length = length_inc;
               state_in.phase  = jnl_pkg::PH_EXP0;
            end else begin
               emit          = 1'b1;
               result.status = finish_status;
               result.value  = finish_value;
            end
         end
         jnl_pkg::PH_EXP0: begin
            if (is_sign) begin
               state_in.length = length_inc;
               state_in.phase  = jnl_pkg::PH_EXPS;
            end else if (is_digit) begin
               state_in.length = length_inc;
               state_in.phase  = jnl_pkg::PH_EXP;
            end else begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_NO_EXP_DIGITS;
            end
         end
         jnl_pkg::PH_EXPS: begin
            if (is_digit) begin
               state_in.length = length_inc;
               state_in.phase  = jnl_pkg::PH_EXP;
            end else begin
               emit          = 1'b1;
               result.status = jnl_pkg::ST_NO_EXP_DIGITS;
            end
         end
         jnl_pkg::PH_EXP: begin
            if (is_digit) begin
               state_in.length = length_inc;
            end else begin
               emit          = 1'b1;
               result.status = finish_status;
               result.value  = finish_value;
            end
         end
         default: begin
            state_in.phase = jnl_pkg::PH_IDLE;
         end
      endcase
      if (emit) begin
         state_in.phase = jnl_pkg::PH_IDLE;
      end
   end

endmodule

[rtl/json_number_lexer_int64.sv]
// ----------------------------------------------------------------------------
// JSON number lexer, int64 result
// Scans a byte stream against the JSON number grammar and reports, for each
// token, an int64 value or the need for double conversion, or a grammar error.
// ----------------------------------------------------------------------------
// The req channel carries one text byte per transfer, with req_tuser set on
// the first byte of a number token. Bytes outside an open token are dropped.
// The first byte that does not fit the grammar closes the token; it is not
// counted in the token and yields exactly one transfer on the rsp channel.
// A new token start over an open token discards the open one silently.
// The rsp channel carries the status in rsp_tuser and the value, integer
// digit count and token length in rsp_tdata.
// Each accepted byte goes through an input register and then one pass of
// grammar logic that updates the lexer state and the result register, so the
// block takes one byte per cycle while no result is stalled. A result is
// stored in the result register as the closing byte leaves the input register.
// When rsp_tready is low with a result pending, the input register holds its
// byte and req_tready drops once that register is full.
// Reset clears the valid flags of both registers and returns the lexer to idle.
// ----------------------------------------------------------------------------
module json_number_lexer_int64 (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,  // char_byte
   input  logic                               req_tuser,  // token_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // int_value[63:0], int_digit_count[68:64], token_length[78:69], zero pad
   output logic [jnl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   output logic [jnl_pkg::STATUS_W-1:0]       rsp_tuser   // status
);

   logic                         in_valid_ff;
   logic [jnl_pkg::CHAR_W-1:0]   char_ff;
   logic                         start_ff;
   jnl_pkg::state_type           state_ff;
   jnl_pkg::state_type           state_in;
   logic                         rsp_valid_ff;
   jnl_pkg::result_type          result_ff;
   jnl_pkg::result_type          result_in;
   logic                         emit;
   logic                         fire;

   jnl_step u_step (
      .state_ff    (state_ff),
      .char_byte   (char_ff),
      .token_start (start_ff),
      .state_in    (state_in),
      .emit        (emit),
      .result      (result_in)
   );

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (fire) begin
            state_ff     <= state_in;
            rsp_valid_ff <= emit;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         char_ff  <= req_tdata;
         start_ff <= req_tuser;
      end
      if (fire && emit) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = result_ff.status;
   assign rsp_tdata  = {1'b0, result_ff.length, result_ff.digit_count, result_ff.value};

endmodule

[rtl/jnl_checker.sv]
// ----------------------------------------------------------------------------
// JSON number lexer checker
// Port-level checks on the result channel of the lexer, bound to the top.
// ----------------------------------------------------------------------------
module jnl_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [jnl_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input logic [jnl_pkg::STATUS_W-1:0]       rsp_tuser
);

   logic ok_status;

   assign ok_status = (rsp_tuser == jnl_pkg::ST_INT_OK);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid after reset.");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed.");

   a_error_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !ok_status |-> (rsp_tdata[63:0] == '0))
      else $error("Nonzero value with a non-integer status.");

   a_leading_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == jnl_pkg::ST_LEADING_ZERO) |->
         (rsp_tdata[68:64] > 5'd1) && (rsp_tdata[78:69] >= 10'd2))
      else $error("Leading zero reported with fewer than two digits.");

   a_ok_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ok_status |->
         (rsp_tdata[68:64] != 5'd0) && (rsp_tdata[68:64] <= jnl_pkg::INT_DIGITS_MAX))
      else $error("Integer result with an impossible digit count.");

endmodule

bind json_number_lexer_int64 jnl_checker u_jnl_checker (.*);

[tb/json_number_lexer_int64_checker.sv]
// ----------------------------------------------------------------------------
// JSON number lexer checker
// Watches both streams of the lexer, runs its own copy of the number grammar
// on every byte transfer to build the expected token results, and compares
// each result transfer field by field with the oldest one still waiting.
// ----------------------------------------------------------------------------
module json_number_lexer_int64_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [7:0]                      req_tdata,  // char_byte
   input  logic                            req_tuser,  // token_start
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // int_value[63:0], int_digit_count[68:64], token_length[78:69], zero pad
   input  logic [jnl_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic [jnl_pkg::STATUS_W-1:0]    rsp_tuser,  // status
   output int unsigned                     results_pending,
   output int unsigned                     mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import jnl_pkg::*;

   phase_type          lex_phase;
   logic               neg_sign;
   logic [VALUE_W-1:0] int_magnitude;
   logic [DIGIT_W-1:0] int_digits;
   logic               lead_zero;
   logic               frac_or_exp;
   logic [LEN_W-1:0]   token_len;
   result_type         token_results_q[$];

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic clear_lexer();
      lex_phase     = PH_IDLE;
      neg_sign      = 1'b0;
      int_magnitude = '0;
      int_digits    = '0;
      lead_zero     = 1'b0;
      frac_or_exp   = 1'b0;
      token_len     = '0;
   endtask

   task automatic bump_length();
      if (token_len < LEN_CAP) begin
         token_len = token_len + 1'b1;
      end
   endtask

   task automatic take_digit(input logic [7:0] c);
      logic [3:0] d;
      d = 4'(c - CH_ZERO);
      if (int_digits == 0) begin
         lead_zero = (d == 0);
      end
      if (int_digits < INT_DIGITS_MAX) begin
         int_magnitude = int_magnitude * 64'd10 + 64'(d);
      end
      if (int_digits < DIGIT_CAP) begin
         int_digits = int_digits + 1'b1;
      end
      bump_length();
      lex_phase = PH_INT;
   endtask

   task automatic close_token(input status_type st, input logic [VALUE_W-1:0] value);
      result_type r;
      r.status      = st;
      r.value       = value;
      r.digit_count = int_digits;
      r.length      = token_len;
      token_results_q.push_back(r);
      lex_phase = PH_IDLE;
   endtask

   task automatic close_number();
      logic [VALUE_W-1:0] limit;
      limit = neg_sign ? NEG_LIMIT : POS_LIMIT;
      if (frac_or_exp || int_digits > INT_DIGITS_MAX ||
          (int_digits == INT_DIGITS_MAX && int_magnitude > limit)) begin
         close_token(ST_NEEDS_DOUBLE, '0);
      end else begin
         close_token(ST_INT_OK, neg_sign ? 64'd0 - int_magnitude : int_magnitude);
      end
   endtask

   task automatic lex_byte(input logic [7:0] c, input logic start);
      logic is_digit;
      logic is_exp;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_exp   = (c == CH_E_UPPER) || (c == CH_E_LOWER);
      if (start) begin
         clear_lexer();
         lex_phase = PH_START;
      end
      case (lex_phase)
         PH_START: begin
            if (c == CH_MINUS) begin
               neg_sign = 1'b1;
               bump_length();
               lex_phase = PH_SIGN;
            end else if (is_digit) begin
               take_digit(c);
            end else begin
               close_token(ST_NO_INT_DIGITS, '0);
            end
         end
         PH_SIGN: begin
            if (is_digit) begin
               take_digit(c);
            end else begin
               close_token(ST_NO_INT_DIGITS, '0);
            end
         end
         PH_INT: begin
            if (is_digit) begin
               take_digit(c);
            end else if (lead_zero && int_digits > 1) begin
               close_token(ST_LEADING_ZERO, '0);
            end else if (c == CH_DOT) begin
               frac_or_exp = 1'b1;
               bump_length();
               lex_phase = PH_FRAC0;
            end else if (is_exp) begin
               frac_or_exp = 1'b1;
               bump_length();
               lex_phase = PH_EXP0;
            end else begin
               close_number();
            end
         end
         PH_FRAC0: begin
            if (is_digit) begin
               bump_length();
               lex_phase = PH_FRAC;
            end else begin
               close_token(ST_NO_FRAC_DIGITS, '0);
            end
         end
         PH_FRAC: begin
            if (is_digit) begin
               bump_length();
            end else if (is_exp) begin
               bump_length();
               lex_phase = PH_EXP0;
            end else begin
               close_number();
            end
         end
         PH_EXP0: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
               bump_length();
               lex_phase = PH_EXPS;
            end else if (is_digit) begin
               bump_length();
               lex_phase = PH_EXP;
            end else begin
               close_token(ST_NO_EXP_DIGITS, '0);
            end
         end
         PH_EXPS: begin
            if (is_digit) begin
               bump_length();
               lex_phase = PH_EXP;
            end else begin
               close_token(ST_NO_EXP_DIGITS, '0);
            end
         end
         PH_EXP: begin
            if (is_digit) begin
               bump_length();
            end else begin
               close_number();
            end
         end
         default: begin
            lex_phase = PH_IDLE;
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         clear_lexer();
         token_results_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (token_results_q.size() == 0) begin
               report_mismatch("result transfer with none expected", rsp_tdata[63:0], '0);
            end else begin
               want = token_results_q.pop_front();
               if (rsp_tuser !== want.status) begin
                  report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
               end
               if (rsp_tdata[63:0] !== want.value) begin
                  report_mismatch("int_value", rsp_tdata[63:0], want.value);
               end
               if (rsp_tdata[68:64] !== want.digit_count) begin
                  report_mismatch("int_digit_count", 64'(rsp_tdata[68:64]),
                                  64'(want.digit_count));
               end
               if (rsp_tdata[78:69] !== want.length) begin
                  report_mismatch("token_length", 64'(rsp_tdata[78:69]), 64'(want.length));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            lex_byte(req_tdata, req_tuser);
         end
      end
      results_pending <= token_results_q.size();
   end

endmodule

[tb/tb_json_number_lexer_int64.sv]
// ----------------------------------------------------------------------------
// JSON number lexer testbench
// Feeds the lexer directed number tokens (int64 limits, fractions, exponents,
// every grammar error, saturating counts) and then random tokens, broken
// tokens and noise, with random gaps on the byte stream and random stalls on
// the result stream. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_json_number_lexer_int64;
   timeunit 1ns;
   timeprecision 1ps;
   import jnl_pkg::*;

   localparam int unsigned RANDOM_BYTES  = 600;
   localparam int unsigned CALM_BYTES    = 120;
   localparam int unsigned CYCLE_LIMIT   = 300000;
   localparam int unsigned SETTLE_CYCLES = 8;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   int unsigned results_pending;
   int unsigned mismatch_count;
   int unsigned cycle_count = 0;
   int unsigned stall_left  = 0;
   int unsigned lexed_bytes = 0;
   logic        calm        = 1'b0;
   logic [7:0]  token_text[$];

   json_number_lexer_int64 uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   json_number_lexer_int64_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .results_pending (results_pending),
      .mismatch_count  (mismatch_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (calm || stall_left == 0) begin
         if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end else begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end
   end

   task automatic drive_byte(input logic [7:0] c, input logic start);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic add_str(input string s);
      for (int i = 0; i < s.len(); i++) begin
         token_text.push_back(s[i]);
      end
   endtask

   task automatic send_token(input logic start);
      foreach (token_text[i]) begin
         drive_byte(token_text[i], start && i == 0);
         lexed_bytes++;
      end
      token_text.delete();
   endtask

   task automatic send_text(input string s);
      add_str(s);
      send_token(1'b1);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   function automatic string rand_digits(input int unsigned n, input logic nonzero_first);
      string s;
      s = "";
      for (int i = 0; i < n; i++) begin
         s = $sformatf("%s%0d", s, (i == 0 && nonzero_first) ? $urandom_range(1, 9)
                                                             : $urandom_range(0, 9));
      end
      return s;
   endfunction

   // A byte that cannot continue a number in any phase.
   function automatic logic [7:0] stray_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_DOT || b == CH_PLUS ||
                 b == CH_MINUS || b == CH_E_UPPER || b == CH_E_LOWER);
      return b;
   endfunction

   initial begin
      int unsigned  pick;
      int unsigned  kind;
      int unsigned  n;
      logic         drained_mid;
      logic [63:0]  near;
      drained_mid = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      send_text("0,");
      send_text("-0,");
      send_text("7]");
      send_text("-42 ");
      send_text("9223372036854775807,");
      send_text("9223372036854775808,");
      send_text("-9223372036854775808,");
      send_text("-9223372036854775809,");
      send_text("12345678901234567890,");
      send_text("1.5,");
      send_text("2e10,");
      send_text("3E-4,");
      send_text("6.02e+23}");
      send_text("0.5,");
      send_text("00,");
      send_text("0123,");
      send_text("-x");
      send_text("--");
      send_text("x");
      send_text("1.x");
      send_text("1ex");
      send_text("1e+x");
      send_text("1.5e7.");
      // Bytes outside a token are dropped.
      add_str("abc");
      send_token(1'b0);
      // A new start drops the open token.
      send_text("123");
      send_text("45,");
      send_text({rand_digits(40, 1'b1), ","});
      add_str("1.");
      add_str(rand_digits(30, 1'b0));
      token_text.push_back(8'h00);
      send_token(1'b1);
      add_str("5");
      token_text.push_back(8'hFF);
      send_token(1'b1);
      drive_byte(8'hFF, 1'b1);
      wait_results();

      lexed_bytes = 0;
      while (lexed_bytes < RANDOM_BYTES) begin
         calm = (lexed_bytes + CALM_BYTES >= RANDOM_BYTES);
         if (!drained_mid && lexed_bytes >= RANDOM_BYTES / 2) begin
            wait_results();
            drained_mid = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            if ($urandom_range(0, 2) == 0) begin
               add_str("-");
            end
            kind = $urandom_range(0, 99);
            n = (kind < 60) ? $urandom_range(1, 4) :
                (kind < 85) ? $urandom_range(5, 18) : $urandom_range(19, 33);
            add_str(rand_digits(n, n > 1));
            if ($urandom_range(0, 3) == 0) begin
               add_str({".", rand_digits($urandom_range(1, 6), 1'b0)});
            end
            if ($urandom_range(0, 3) == 0) begin
               add_str($urandom_range(0, 1) ? "e" : "E");
               kind = $urandom_range(0, 2);
               if (kind == 1) begin
                  add_str("+");
               end else if (kind == 2) begin
                  add_str("-");
               end
               add_str(rand_digits($urandom_range(1, 3), 1'b0));
            end
            token_text.push_back(stray_byte());
            send_token(1'b1);
         end else if (pick < 65) begin
            if ($urandom_range(0, 1)) begin
               add_str("-");
            end
            if ($urandom_range(0, 3) == 0) begin
               add_str(rand_digits(19, 1'b1));
            end else begin
               near = 64'd9223372036854775800 + 64'($urandom_range(0, 15));
               add_str($sformatf("%0d", near));
            end
            token_text.push_back(stray_byte());
            send_token(1'b1);
         end else if (pick < 80) begin
            kind = $urandom_range(0, 5);
            case (kind)
               0: add_str({"0", rand_digits($urandom_range(1, 4), 1'b0)});
               1: add_str("-");
               2: ;
               3: add_str({rand_digits($urandom_range(1, 3), 1'b1), "."});
               4: add_str({rand_digits($urandom_range(1, 3), 1'b1),
                           $urandom_range(0, 1) ? "e" : "E"});
               default: add_str({rand_digits($urandom_range(1, 3), 1'b1), "e",
                                 $urandom_range(0, 1) ? "+" : "-"});
            endcase
            token_text.push_back(stray_byte());
            send_token(1'b1);
         end else if (pick < 88) begin
            if ($urandom_range(0, 1)) begin
               add_str("-");
            end
            add_str(rand_digits($urandom_range(1, 6), 1'b1));
            send_token(1'b1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               drive_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
               lexed_bytes++;
            end
         end
      end

      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
